// ----- rtl/rfit_pkg.sv -----
// Shared types, constants and saturation helpers for the RLS ellipsoid fit block.
package rfit_pkg;

   localparam int NUM_COEFS = 9;
   localparam int NUM_CELLS = NUM_COEFS * NUM_COEFS;
   localparam int NUM_QUAD  = 3;
   localparam int REG_TERMS = 6;
   localparam int COEF_W    = 48;
   localparam int MUL_W     = COEF_W + 1;
   localparam int ACC_W     = COEF_W + 5;
   localparam int CFG_W     = 47;
   localparam int SAMPLE_W  = 24;
   localparam int IDX_W     = 4;
   localparam int CELL_W    = 7;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_NOISE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PQUAD  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_POTHER = 2'd2;

   localparam logic [CFG_W-1:0] NOISE_RST  = 47'd4294967;
   localparam logic [CFG_W-1:0] PQUAD_RST  = 47'd42949672960;
   localparam logic [CFG_W-1:0] POTHER_RST = 47'd4294967296;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_COEFS - 1);
   localparam logic [IDX_W-1:0] LAST_REG = IDX_W'(REG_TERMS - 1);

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [MUL_W-1:0]  opnd_type;
   typedef logic signed [ACC_W-1:0]  acc_type;

   localparam coef_type COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
   localparam coef_type COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_FETCH = 6'b000010,
      S_OPER  = 6'b000100,
      S_WAIT  = 6'b001000,
      S_DWAIT = 6'b010000,
      S_EMIT  = 6'b100000
   } state_type;

   typedef enum logic [5:0] {
      PH_REG = 6'b000001,
      PH_DV  = 6'b000010,
      PH_PD  = 6'b000100,
      PH_UD  = 6'b001000,
      PH_DIV = 6'b010000,
      PH_PU  = 6'b100000
   } phase_type;

   typedef enum logic [3:0] {
      MS_IDLE = 4'b0001,
      MS_LO   = 4'b0010,
      MS_HI   = 4'b0100,
      MS_RND  = 4'b1000
   } mul_state_type;

   typedef enum logic [2:0] {
      DS_IDLE = 3'b001,
      DS_RUN  = 3'b010,
      DS_FIN  = 3'b100
   } div_state_type;

   function automatic coef_type sat_coef(input acc_type v);
      coef_type r;
      if (v > acc_type'(COEF_MAX)) begin
         r = COEF_MAX;
      end else if (v < acc_type'(COEF_MIN)) begin
         r = COEF_MIN;
      end else begin
         r = COEF_W'(v);
      end
      return r;
   endfunction

   // magnitude plus sign to a saturated signed value
   function automatic coef_type apply_sign(input logic [COEF_W-2:0] mag, input logic neg,
                                           input logic big);
      coef_type r;
      if (big) begin
         r = neg ? COEF_MIN : COEF_MAX;
      end else if (neg) begin
         r = -coef_type'({1'b0, mag});
      end else begin
         r = coef_type'({1'b0, mag});
      end
      return r;
   endfunction

endpackage

// ----- rtl/rfit_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rfit_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 81
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rfit_mul.sv -----
// Shared fixed-point multiplier: two partial products, round half away, saturate.
module rfit_mul #(
   parameter int FRAC_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  rfit_pkg::opnd_type a,
   input  rfit_pkg::opnd_type b,
   output logic               done,
   output rfit_pkg::coef_type res
);
   import rfit_pkg::*;

   localparam int LO_W   = 25;
   localparam int PP_W   = MUL_W + LO_W;
   localparam int PROD_W = 2 * MUL_W;

   mul_state_type       mstate_ff, mstate_in;
   logic [MUL_W-1:0]    ma_ff, ma_in, mb_ff, mb_in;
   logic                neg_ff, neg_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic                done_ff, done_in;
   coef_type            res_ff, res_in;
   logic [LO_W-1:0]     mb_part;
   logic [PP_W-1:0]     pp;
   logic [PROD_W-1:0]   rnd;
   logic [PROD_W-1:0]   rsh;

   always_comb begin
      mb_part = (mstate_ff == MS_LO) ? mb_ff[LO_W-1:0] : LO_W'(mb_ff[MUL_W-1:LO_W]);
      pp      = PP_W'(ma_ff) * PP_W'(mb_part);
      rnd     = prod_ff + (PROD_W'(1) << (FRAC_BITS - 1));
      rsh     = rnd >> FRAC_BITS;
   end

   always_comb begin
      mstate_in = mstate_ff;
      ma_in     = ma_ff;
      mb_in     = mb_ff;
      neg_in    = neg_ff;
      prod_in   = prod_ff;
      done_in   = 1'b0;
      res_in    = res_ff;
      unique case (mstate_ff)
         MS_IDLE: begin
            if (start) begin
               ma_in     = a[MUL_W-1] ? MUL_W'(-a) : MUL_W'(a);
               mb_in     = b[MUL_W-1] ? MUL_W'(-b) : MUL_W'(b);
               neg_in    = a[MUL_W-1] ^ b[MUL_W-1];
               mstate_in = MS_LO;
            end
         end
         MS_LO: begin
            prod_in   = PROD_W'(pp);
            mstate_in = MS_HI;
         end
         MS_HI: begin
            prod_in   = prod_ff + (PROD_W'(pp) << LO_W);
            mstate_in = MS_RND;
         end
         MS_RND: begin
            res_in    = apply_sign(rsh[COEF_W-2:0], neg_ff, |rsh[PROD_W-1:COEF_W-1]);
            done_in   = 1'b1;
            mstate_in = MS_IDLE;
         end
         default: mstate_in = MS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mstate_ff <= MS_IDLE;
         done_ff   <= 1'b0;
      end else begin
         mstate_ff <= mstate_in;
         done_ff   <= done_in;
      end
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      res_ff  <= res_in;
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule

// ----- rtl/rfit_div.sv -----
// Bit-serial restoring divider for the gain: (n << FRAC_BITS) / d, rounded and saturated.
module rfit_div #(
   parameter int FRAC_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  rfit_pkg::coef_type num,
   input  rfit_pkg::coef_type den,
   output logic               done,
   output rfit_pkg::coef_type quo
);
   import rfit_pkg::*;

   localparam int NUM_W  = COEF_W + FRAC_BITS;
   localparam int QUO_W  = COEF_W + 2;
   localparam int HEAD_W = NUM_W - QUO_W;
   localparam int REM_W  = COEF_W + 1;
   localparam int CNT_W  = $clog2(QUO_W);
   localparam logic [QUO_W-1:0] QUO_LIM  = QUO_W'(1) << COEF_W;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

   div_state_type       dstate_ff, dstate_in;
   logic [COEF_W-1:0]   ud_ff, ud_in;
   logic                neg_ff, neg_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [QUO_W-1:0]    low_ff, low_in, q_ff, q_in;
   logic                over_ff, over_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                done_ff, done_in;
   coef_type            quo_ff, quo_in;
   logic [COEF_W-1:0]   un, udv;
   logic [NUM_W-1:0]    nfull;
   logic [HEAD_W-1:0]   head;
   logic [REM_W-1:0]    trial;
   logic                ge;
   logic                over_fin, rnd;
   logic [QUO_W:0]      qr;

   always_comb begin
      un       = num[COEF_W-1] ? COEF_W'(-num) : COEF_W'(num);
      udv      = den[COEF_W-1] ? COEF_W'(-den) : COEF_W'(den);
      nfull    = NUM_W'(un) << FRAC_BITS;
      head     = nfull[NUM_W-1:QUO_W];
      trial    = {rem_ff[REM_W-2:0], low_ff[QUO_W-1]};
      ge       = trial >= REM_W'(ud_ff);
      over_fin = over_ff || (q_ff > QUO_LIM);
      rnd      = {rem_ff[REM_W-2:0], 1'b0} >= REM_W'(ud_ff);
      qr       = (QUO_W+1)'(q_ff) + (QUO_W+1)'(rnd);
   end

   always_comb begin
      dstate_in = dstate_ff;
      ud_in     = ud_ff;
      neg_in    = neg_ff;
      rem_in    = rem_ff;
      low_in    = low_ff;
      q_in      = q_ff;
      over_in   = over_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      quo_in    = quo_ff;
      unique case (dstate_ff)
         DS_IDLE: begin
            if (start) begin
               ud_in     = udv;
               neg_in    = num[COEF_W-1] ^ den[COEF_W-1];
               rem_in    = REM_W'(head);
               over_in   = REM_W'(head) >= REM_W'(udv);
               low_in    = nfull[QUO_W-1:0];
               q_in      = '0;
               cnt_in    = '0;
               dstate_in = DS_RUN;
            end
         end
         DS_RUN: begin
            rem_in = ge ? trial - REM_W'(ud_ff) : trial;
            q_in   = {q_ff[QUO_W-2:0], ge};
            low_in = low_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               dstate_in = DS_FIN;
            end
         end
         DS_FIN: begin
            quo_in    = apply_sign(qr[COEF_W-2:0], neg_ff, over_fin || (|qr[QUO_W:COEF_W-1]));
            done_in   = 1'b1;
            dstate_in = DS_IDLE;
         end
         default: dstate_in = DS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dstate_ff <= DS_IDLE;
         done_ff   <= 1'b0;
      end else begin
         dstate_ff <= dstate_in;
         done_ff   <= done_in;
      end
      ud_ff   <= ud_in;
      neg_ff  <= neg_in;
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      q_ff    <= q_in;
      over_ff <= over_in;
      cnt_ff  <= cnt_in;
      quo_ff  <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ----- rtl/rls_ellipsoid_fit_update.sv -----
// Top level of the recursive-least-squares ellipsoid fit update block.
//
//  channel | dir | fields (low bit first)                           | transaction
//  req     | in  | tdata: sample_x, sample_y, sample_z; tuser: mode | tvalid & tready
//  rsp     | out | tdata: coef_value; tuser: coef_index; tlast     | tvalid & tready
//  csr     | in  | csr_index, csr_data                              | csr_valid & csr_ready
//
// Every product goes through one shared 49x25 multiplier, and an update is dominated by
// the two 81-entry covariance passes and nine gain divisions. Restart is done in S_IDLE.
// Reset needs no clearing pass: per-entry valid bits stand in for the initial covariance.
// req_tready is low while an update runs and while its nine results are handed out;
// a stalled rsp holds the sequencer in its output state.
module rls_ellipsoid_fit_update #(
   parameter int FRAC_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [3*rfit_pkg::SAMPLE_W-1:0]        req_tdata,   // sample_x, sample_y, sample_z
   input  logic                                   req_tuser,   // mode
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [rfit_pkg::COEF_W-1:0]            rsp_tdata,   // coef_value
   output logic [rfit_pkg::IDX_W-1:0]             rsp_tuser,   // coef_index
   output logic                                   rsp_tlast,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [rfit_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [rfit_pkg::CFG_W-1:0]             csr_data
);
   import rfit_pkg::*;

   state_type                      state_ff, state_in;
   phase_type                      phase_ff, phase_in;
   logic [IDX_W-1:0]               i_ff, i_in, j_ff, j_in;
   logic [CELL_W-1:0]              cell_ff, cell_in;
   acc_type                        acc_ff, acc_in;
   logic signed [SAMPLE_W-1:0]     x_ff, x_in, y_ff, y_in, z_ff, z_in;
   coef_type                       d_ff [NUM_COEFS];
   coef_type                       d_in [NUM_COEFS];
   coef_type                       u_ff [NUM_COEFS];
   coef_type                       u_in [NUM_COEFS];
   coef_type                       k_ff [NUM_COEFS];
   coef_type                       k_in [NUM_COEFS];
   coef_type                       v_ff [NUM_COEFS];
   coef_type                       v_in [NUM_COEFS];
   coef_type                       yv_ff, yv_in, s_ff, s_in;
   logic [CFG_W-1:0]               noise_ff, noise_in, pquad_cfg_ff, pquad_cfg_in;
   logic [CFG_W-1:0]               pother_cfg_ff, pother_cfg_in;
   logic [CFG_W-1:0]               pquad_ff, pquad_in, pother_ff, pother_in;
   logic [NUM_CELLS-1:0]           vld_ff, vld_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   coef_type                       rsp_value_ff, rsp_value_in;
   logic [IDX_W-1:0]               rsp_index_ff, rsp_index_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic                           mul_start, mul_done;
   opnd_type                       mul_a, mul_b;
   coef_type                       mres;
   logic                           div_start, div_done;
   coef_type                       div_q;
   logic                           ram_we;
   logic [COEF_W-1:0]              ram_rd;
   coef_type                       p_new, pval, p_init, dv, s_new;
   logic [IDX_W-1:0]               rd_idx;
   coef_type                       d_rd, u_rd;
   acc_type                        acc_sum;
   opnd_type                       xs, ys, zs, xs2, ys2, zs2;
   logic                           restart_go;

   rfit_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .res   (mres)
   );

   rfit_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (u_rd),
      .den   (s_ff),
      .done  (div_done),
      .quo   (div_q)
   );

   rfit_ram #(.WIDTH(COEF_W), .DEPTH(NUM_CELLS)) u_cov_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cell_ff),
      .wr_data (p_new),
      .rd_en   (state_ff == S_FETCH),
      .rd_addr (cell_ff),
      .rd_data (ram_rd)
   );

   always_comb begin
      xs      = opnd_type'(x_ff) <<< (FRAC_BITS - 16);
      ys      = opnd_type'(y_ff) <<< (FRAC_BITS - 16);
      zs      = opnd_type'(z_ff) <<< (FRAC_BITS - 16);
      xs2     = opnd_type'(x_ff) <<< (FRAC_BITS - 15);
      ys2     = opnd_type'(y_ff) <<< (FRAC_BITS - 15);
      zs2     = opnd_type'(z_ff) <<< (FRAC_BITS - 15);
      rd_idx  = (phase_ff == PH_PD || phase_ff == PH_PU) ? j_ff : i_ff;
      d_rd    = d_ff[rd_idx];
      u_rd    = u_ff[rd_idx];
      p_init  = '0;
      if (i_ff == j_ff) begin
         p_init = (i_ff < IDX_W'(NUM_QUAD)) ? coef_type'({1'b0, pquad_ff})
                                            : coef_type'({1'b0, pother_ff});
      end
      pval    = vld_ff[cell_ff] ? coef_type'(ram_rd) : p_init;
      acc_sum = acc_ff + acc_type'(mres);
      p_new   = sat_coef(acc_type'(pval) - acc_type'(mres));
      dv      = sat_coef(acc_sum);
      s_new   = sat_coef(acc_type'(sat_coef(acc_sum)) + acc_type'({1'b0, noise_ff}));
   end

   // multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == S_DWAIT) begin
         mul_a = opnd_type'(div_q);
         mul_b = opnd_type'(yv_ff);
      end else begin
         unique case (phase_ff)
            PH_REG: begin
               unique case (i_ff)
                  4'd0:    begin mul_a = xs; mul_b = xs;  end
                  4'd1:    begin mul_a = ys; mul_b = ys;  end
                  4'd2:    begin mul_a = zs; mul_b = zs;  end
                  4'd3:    begin mul_a = xs; mul_b = ys2; end
                  4'd4:    begin mul_a = xs; mul_b = zs2; end
                  default: begin mul_a = ys; mul_b = zs2; end
               endcase
            end
            PH_DV:   begin mul_a = opnd_type'(d_rd);     mul_b = opnd_type'(v_ff[i_ff]); end
            PH_PD:   begin mul_a = opnd_type'(pval);     mul_b = opnd_type'(d_rd);       end
            PH_UD:   begin mul_a = opnd_type'(u_rd);     mul_b = opnd_type'(d_rd);       end
            PH_PU:   begin mul_a = opnd_type'(k_ff[i_ff]); mul_b = opnd_type'(u_rd);     end
            default: begin mul_a = '0;                   mul_b = '0;                     end
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      cell_in       = cell_ff;
      acc_in        = acc_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      d_in          = d_ff;
      u_in          = u_ff;
      k_in          = k_ff;
      v_in          = v_ff;
      yv_in         = yv_ff;
      s_in          = s_ff;
      noise_in      = noise_ff;
      pquad_cfg_in  = pquad_cfg_ff;
      pother_cfg_in = pother_cfg_ff;
      pquad_in      = pquad_ff;
      pother_in     = pother_ff;
      vld_in        = vld_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_last_in   = rsp_last_ff;
      mul_start     = 1'b0;
      div_start     = 1'b0;
      ram_we        = 1'b0;
      restart_go    = 1'b0;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         unique case (csr_index)
            REG_NOISE:  noise_in      = csr_data;
            REG_PQUAD:  pquad_cfg_in  = csr_data;
            REG_POTHER: pother_cfg_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser) begin
                  restart_go = 1'b1;
                  for (int n = 0; n < NUM_COEFS; n++) begin
                     v_in[n] = '0;
                  end
                  vld_in    = '0;
                  pquad_in  = pquad_cfg_ff;
                  pother_in = pother_cfg_ff;
               end else begin
                  x_in     = req_tdata[SAMPLE_W-1:0];
                  y_in     = req_tdata[2*SAMPLE_W-1:SAMPLE_W];
                  z_in     = req_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
                  phase_in = PH_REG;
                  i_in     = '0;
                  state_in = S_OPER;
               end
            end
         end
         S_FETCH: state_in = S_OPER;
         S_OPER: begin
            if (phase_ff == PH_DIV) begin
               div_start = 1'b1;
               state_in  = S_DWAIT;
            end else begin
               mul_start = 1'b1;
               state_in  = S_WAIT;
            end
         end
         S_DWAIT: begin
            if (div_done) begin
               k_in[i_ff] = div_q;
               mul_start  = 1'b1;
               state_in   = S_WAIT;
            end
         end
         S_WAIT: begin
            if (mul_done) begin
               unique case (phase_ff)
                  PH_REG: begin
                     d_in[i_ff] = mres;
                     state_in   = S_OPER;
                     if (i_ff == LAST_REG) begin
                        d_in[6]  = sat_coef(acc_type'(xs2));
                        d_in[7]  = sat_coef(acc_type'(ys2));
                        d_in[8]  = sat_coef(acc_type'(zs2));
                        phase_in = PH_DV;
                        i_in     = '0;
                        acc_in   = '0;
                     end else begin
                        i_in = i_ff + 1'b1;
                     end
                  end
                  PH_DV: begin
                     if (i_ff == LAST_IDX) begin
                        yv_in    = sat_coef((acc_type'(1) <<< FRAC_BITS) - acc_type'(dv));
                        phase_in = PH_PD;
                        i_in     = '0;
                        j_in     = '0;
                        cell_in  = '0;
                        acc_in   = '0;
                        state_in = S_FETCH;
                     end else begin
                        acc_in   = acc_sum;
                        i_in     = i_ff + 1'b1;
                        state_in = S_OPER;
                     end
                  end
                  PH_PD: begin
                     cell_in = cell_ff + 1'b1;
                     if (j_ff == LAST_IDX) begin
                        u_in[i_ff] = sat_coef(acc_sum);
                        acc_in     = '0;
                        j_in       = '0;
                        if (i_ff == LAST_IDX) begin
                           phase_in = PH_UD;
                           i_in     = '0;
                           state_in = S_OPER;
                        end else begin
                           i_in     = i_ff + 1'b1;
                           state_in = S_FETCH;
                        end
                     end else begin
                        acc_in   = acc_sum;
                        j_in     = j_ff + 1'b1;
                        state_in = S_FETCH;
                     end
                  end
                  PH_UD: begin
                     if (i_ff == LAST_IDX) begin
                        s_in = s_new;
                        i_in = '0;
                        if (s_new == '0) begin
                           state_in = S_EMIT;
                        end else begin
                           phase_in = PH_DIV;
                           state_in = S_OPER;
                        end
                     end else begin
                        acc_in   = acc_sum;
                        i_in     = i_ff + 1'b1;
                        state_in = S_OPER;
                     end
                  end
                  PH_DIV: begin
                     v_in[i_ff] = sat_coef(acc_type'(v_ff[i_ff]) + acc_type'(mres));
                     if (i_ff == LAST_IDX) begin
                        phase_in = PH_PU;
                        i_in     = '0;
                        j_in     = '0;
                        cell_in  = '0;
                        state_in = S_FETCH;
                     end else begin
                        i_in     = i_ff + 1'b1;
                        state_in = S_OPER;
                     end
                  end
                  PH_PU: begin
                     ram_we          = 1'b1;
                     vld_in[cell_ff] = 1'b1;
                     cell_in         = cell_ff + 1'b1;
                     state_in        = S_FETCH;
                     if (j_ff == LAST_IDX) begin
                        j_in = '0;
                        if (i_ff == LAST_IDX) begin
                           i_in     = '0;
                           state_in = S_EMIT;
                        end else begin
                           i_in = i_ff + 1'b1;
                        end
                     end else begin
                        j_in = j_ff + 1'b1;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = v_ff[i_ff];
               rsp_index_in = i_ff;
               rsp_last_in  = (i_ff == LAST_IDX);
               if (i_ff == LAST_IDX) begin
                  state_in = S_IDLE;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= PH_REG;
         noise_ff      <= NOISE_RST;
         pquad_cfg_ff  <= PQUAD_RST;
         pother_cfg_ff <= POTHER_RST;
         pquad_ff      <= PQUAD_RST;
         pother_ff     <= POTHER_RST;
         vld_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int n = 0; n < NUM_COEFS; n++) begin
            v_ff[n] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         noise_ff      <= noise_in;
         pquad_cfg_ff  <= pquad_cfg_in;
         pother_cfg_ff <= pother_cfg_in;
         pquad_ff      <= pquad_in;
         pother_ff     <= pother_in;
         vld_ff        <= vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         v_ff          <= v_in;
      end
      i_ff         <= i_in;
      j_ff         <= j_in;
      cell_ff      <= cell_in;
      acc_ff       <= acc_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      z_ff         <= z_in;
      d_ff         <= d_in;
      u_ff         <= u_in;
      k_ff         <= k_in;
      yv_ff        <= yv_in;
      s_ff         <= s_in;
      rsp_value_ff <= rsp_value_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_index_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_mul_latency: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> ##4 mul_done)
      else $error("multiplier result not back four cycles after start");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DWAIT))
      else $error("divider finished outside the gain step");

   a_restart_clear: assert property (@(posedge clock) disable iff (reset)
      restart_go |=> (vld_ff == '0) && (v_ff[0] == '0))
      else $error("restart left covariance or coefficients loaded");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tuser == LAST_IDX))
      else $error("tlast on a coefficient other than the ninth");

endmodule

// ----- bench/rls_ellipsoid_fit_update_test.sv -----
// Self-checking bench for the RLS ellipsoid fit block with random stream pressure.
module rls_ellipsoid_fit_update_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rfit_pkg::*;

   localparam int QF = 32;
   localparam int CSR_IDLE_CYCLES = 40;
   localparam int DRAIN_CYCLES = 2000;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic [IDX_W-1:0] index;
      coef_type         value;
      logic             last;
   } coef_result_type;

   class fit_scoreboard;
      logic [CFG_W-1:0] noise_var, pquad_var, pother_var;
      coef_type         coefs[NUM_COEFS];
      coef_type         cov[NUM_COEFS][NUM_COEFS];
      coef_result_type  pending_coefs[$];
      int               fails;

      function new();
         noise_var  = NOISE_RST;
         pquad_var  = PQUAD_RST;
         pother_var = POTHER_RST;
         fails = 0;
         restart_fit();
      endfunction

      function void restart_fit();
         for (int i = 0; i < NUM_COEFS; i++) begin
            coefs[i] = '0;
            for (int j = 0; j < NUM_COEFS; j++) begin
               cov[i][j] = '0;
            end
            cov[i][i] = coef_type'({1'b0, (i < NUM_QUAD) ? pquad_var : pother_var});
         end
      endfunction

      function void note_config(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
         case (idx)
            REG_NOISE:  noise_var  = val;
            REG_PQUAD:  pquad_var  = val;
            REG_POTHER: pother_var = val;
            default: ;
         endcase
      endfunction

      function coef_type sat_wide(wide_type v);
         coef_type r;
         if (v > wide_type'(COEF_MAX)) r = COEF_MAX;
         else if (v < wide_type'(COEF_MIN)) r = COEF_MIN;
         else r = coef_type'(v);
         return r;
      endfunction

      function coef_type signed_mag(wide_type m, logic neg);
         return sat_wide(neg ? -m : m);
      endfunction

      function wide_type mag(coef_type v);
         wide_type w;
         w = wide_type'(v);
         return (w < 0) ? -w : w;
      endfunction

      function coef_type mul_round(coef_type a, coef_type b);
         wide_type m;
         m = mag(a) * mag(b);
         m = (m + (wide_type'(1) <<< (QF - 1))) >>> QF;
         return signed_mag(m, (a < 0) != (b < 0));
      endfunction

      function coef_type div_round(coef_type n, coef_type d);
         wide_type un, ud, q, r;
         un = mag(n) <<< QF;
         ud = mag(d);
         q = un / ud;
         r = un % ud;
         if (2 * r >= ud) q = q + 1;
         return signed_mag(q, (n < 0) != (d < 0));
      endfunction

      function void note_request(logic mode, logic signed [SAMPLE_W-1:0] sx,
                                 logic signed [SAMPLE_W-1:0] sy,
                                 logic signed [SAMPLE_W-1:0] sz);
         coef_type        d[NUM_COEFS], u[NUM_COEFS], k[NUM_COEFS];
         coef_type        dv, innov, denom;
         wide_type        acc, x, y, z;
         coef_result_type res;
         if (mode) begin
            restart_fit();
            return;
         end
         x = wide_type'(sx);
         y = wide_type'(sy);
         z = wide_type'(sz);
         d[0] = sat_wide(x * x);
         d[1] = sat_wide(y * y);
         d[2] = sat_wide(z * z);
         d[3] = sat_wide(2 * x * y);
         d[4] = sat_wide(2 * x * z);
         d[5] = sat_wide(2 * y * z);
         d[6] = sat_wide((2 * x) <<< 16);
         d[7] = sat_wide((2 * y) <<< 16);
         d[8] = sat_wide((2 * z) <<< 16);
         acc = 0;
         for (int i = 0; i < NUM_COEFS; i++) acc += wide_type'(mul_round(d[i], coefs[i]));
         dv = sat_wide(acc);
         innov = sat_wide((wide_type'(1) <<< QF) - wide_type'(dv));
         for (int i = 0; i < NUM_COEFS; i++) begin
            acc = 0;
            for (int j = 0; j < NUM_COEFS; j++) acc += wide_type'(mul_round(cov[i][j], d[j]));
            u[i] = sat_wide(acc);
         end
         acc = 0;
         for (int i = 0; i < NUM_COEFS; i++) acc += wide_type'(mul_round(u[i], d[i]));
         denom = sat_wide(wide_type'(sat_wide(acc)) + wide_type'({1'b0, noise_var}));
         if (denom != 0) begin
            for (int i = 0; i < NUM_COEFS; i++) begin
               k[i] = div_round(u[i], denom);
               coefs[i] = sat_wide(wide_type'(coefs[i]) + wide_type'(mul_round(k[i], innov)));
            end
            for (int i = 0; i < NUM_COEFS; i++)
               for (int j = 0; j < NUM_COEFS; j++)
                  cov[i][j] = sat_wide(wide_type'(cov[i][j])
                                       - wide_type'(mul_round(k[i], u[j])));
         end
         for (int i = 0; i < NUM_COEFS; i++) begin
            res.index = IDX_W'(i);
            res.value = coefs[i];
            res.last  = (i == NUM_COEFS - 1);
            pending_coefs.push_back(res);
         end
      endfunction

      function void check_coef(logic [IDX_W-1:0] idx, coef_type val, logic lst);
         coef_result_type e;
         if (pending_coefs.size() == 0) begin
            fails++;
            if (fails <= 10) $display("unexpected coef transaction idx=%0d val=%0d", idx, val);
            return;
         end
         e = pending_coefs.pop_front();
         if (e.index !== idx || e.value !== val || e.last !== lst) begin
            fails++;
            if (fails <= 10)
               $display("coef mismatch: exp idx=%0d val=%0d last=%0b got idx=%0d val=%0d last=%0b",
                        e.index, e.value, e.last, idx, val, lst);
         end
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [3*SAMPLE_W-1:0]         req_tdata;
   logic                          req_tuser;
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [COEF_W-1:0]             rsp_tdata;
   logic [IDX_W-1:0]              rsp_tuser;
   logic                          rsp_tlast;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [CSR_IDX_W-1:0]          csr_index;
   logic [CFG_W-1:0]              csr_data;

   fit_scoreboard fit_sb = new();

   rls_ellipsoid_fit_update u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   initial begin
      #100_000_000;
      $display("rls_ellipsoid_fit_update_test NOT OK");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         fit_sb.check_coef(rsp_tuser, coef_type'(rsp_tdata), rsp_tlast);
      end
   end

   // result side backpressure
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         gap = $urandom_range(0, 11);
         if (gap > 0) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_sample(logic mode, logic signed [SAMPLE_W-1:0] sx,
                              logic signed [SAMPLE_W-1:0] sy,
                              logic signed [SAMPLE_W-1:0] sz);
      int gap;
      gap = $urandom_range(0, 11);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {sz, sy, sx};
      do @(posedge clock); while (!req_tready);
      fit_sb.note_request(mode, sx, sy, sz);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (fit_sb.pending_coefs.size() != 0) @(posedge clock);
      repeat (CSR_IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      fit_sb.note_config(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_fit_regs(logic [CFG_W-1:0] nv, logic [CFG_W-1:0] qv,
                               logic [CFG_W-1:0] ov);
      wait_drained();
      write_reg(REG_NOISE, nv);
      write_reg(REG_PQUAD, qv);
      write_reg(REG_POTHER, ov);
      write_reg(REG_UNUSED, CFG_W'({$urandom, $urandom}));
   endtask

   function automatic logic signed [SAMPLE_W-1:0] rand_axis();
      logic signed [SAMPLE_W-1:0] v;
      case ($urandom_range(0, 19))
         0: v = SAMPLE_W'($urandom);
         1: v = $urandom_range(0, 1) ? 24'sh7FFFFF : -24'sh800000;
         2: v = SAMPLE_W'($urandom_range(0, 8191)) - 24'sd4096;
         default: v = SAMPLE_W'($urandom_range(0, 196608)) - 24'sd98304;
      endcase
      return v;
   endfunction

   initial begin
      logic [CFG_W-1:0] nv, qv, ov;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = REG_NOISE;
      csr_data   = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: default registers
      send_sample(1'b0, 24'sd0, 24'sd0, 24'sd0);
      send_sample(1'b0, 24'sd65536, 24'sd0, 24'sd0);
      send_sample(1'b0, 24'sd0, -24'sd65536, 24'sd0);
      send_sample(1'b0, 24'sd0, 24'sd0, 24'sd65536);
      send_sample(1'b0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
      send_sample(1'b0, -24'sh800000, -24'sh800000, -24'sh800000);
      send_sample(1'b0, 24'sh7FFFFF, -24'sh800000, 24'sd1);
      send_sample(1'b1, 24'shFFFFFF, 24'shFFFFFF, 24'shFFFFFF);
      send_sample(1'b0, 24'sd37837, 24'sd37837, 24'sd37837);
      send_sample(1'b0, -24'sd46341, 24'sd46341, -24'sd1);
      send_sample(1'b1, 24'sd0, 24'sd0, 24'sd0);
      // zero denominator
      set_fit_regs('0, '0, '0);
      send_sample(1'b1, 24'sd0, 24'sd0, 24'sd0);
      send_sample(1'b0, 24'sd65536, 24'sd65536, 24'sd65536);
      send_sample(1'b0, 24'sd0, 24'sd0, 24'sd0);
      set_fit_regs({CFG_W{1'b1}}, {CFG_W{1'b1}}, {CFG_W{1'b1}});
      send_sample(1'b1, 24'sd0, 24'sd0, 24'sd0);
      send_sample(1'b0, 24'sd65536, -24'sd32768, 24'sd12345);
      send_sample(1'b0, 24'sh7FFFFF, 24'sh7FFFFF, -24'sh800000);
      // register change without restart: P keeps its values, R applies at once
      set_fit_regs(NOISE_RST, PQUAD_RST, POTHER_RST);
      send_sample(1'b0, 24'sd0, 24'sd0, 24'sd0);
      send_sample(1'b1, 24'sd0, 24'sd0, 24'sd0);

      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: begin nv = NOISE_RST; qv = PQUAD_RST; ov = POTHER_RST; end
            1: begin nv = 47'd1; qv = {CFG_W{1'b1}}; ov = '0; end
            2: begin nv = {CFG_W{1'b1}}; qv = '0; ov = {CFG_W{1'b1}}; end
            3: begin nv = '0; qv = 47'd4294967296; ov = 47'd4294967296; end
            default: begin
               nv = CFG_W'($urandom_range(0, 1 << 28));
               qv = CFG_W'({$urandom_range(0, 255), $urandom});
               ov = CFG_W'({$urandom_range(0, 31), $urandom});
            end
         endcase
         set_fit_regs(nv, qv, ov);
         send_sample(1'b1, rand_axis(), rand_axis(), rand_axis());
         for (int n = 0; n < 64; n++) begin
            if (ph == 4 && n == 30) wait_drained();
            send_sample($urandom_range(0, 19) == 0, rand_axis(), rand_axis(), rand_axis());
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fit_sb.fails == 0 && fit_sb.pending_coefs.size() == 0) begin
         $display("rls_ellipsoid_fit_update_test OK");
      end else begin
         $display("rls_ellipsoid_fit_update_test NOT OK");
      end
      $finish;
   end

endmodule
